// File: hw/rtl/angle_kalman_filter_defines.svh
// Assertion macros shared by the angle Kalman filter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ANGLE_KALMAN_FILTER_DEFINES_SVH
`define ANGLE_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AKF_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/akf_pkg.sv
// Shared types, widths and constants of the angle Kalman filter.
// No dependencies; imported by akf_mul, akf_div and the top level.
`timescale 1ns / 1ps

package akf_pkg;

   // field and state widths
   localparam int ACCEL_W     = 25;
   localparam int GYRO_W      = 28;
   localparam int ANGLE_OUT_W = 26;
   localparam int RATE_OUT_W  = 29;
   localparam int CFG_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int EST_W       = 32;
   localparam int COV_W       = 40;

   // serial datapath widths
   localparam int OPND_W    = 42;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int RES_W     = 56;
   localparam int SUM_W     = 58;
   localparam int DEN_W     = 41;
   localparam int MUL_STEPS = OPND_W;
   localparam int GAIN_FRAC = 28;
   localparam int GAIN_INT  = 11;
   localparam int DIV_STEPS = GAIN_FRAC + GAIN_INT;
   localparam int SHIFT_LONG  = 32;
   localparam int SHIFT_SHORT = 28;

   localparam logic signed [COV_W-1:0] COV_ONE = 40'sd268435456;
   localparam logic signed [COV_W-1:0] COV_MAX = 40'sh7f_ffff_ffff;
   localparam logic signed [COV_W-1:0] COV_MIN = 40'sh80_0000_0000;

   localparam logic [CFG_W-1:0] ANGLE_NOISE_RST  = 32'd268435;
   localparam logic [CFG_W-1:0] BIAS_NOISE_RST   = 32'd805306;
   localparam logic [CFG_W-1:0] MEAS_NOISE_RST   = 32'd134217728;
   localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 32'd21474836;

   typedef struct packed {
      logic                     start;
      logic                     shift_long;
      logic signed [OPND_W-1:0] a;
      logic signed [OPND_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [RES_W-1:0] mag;
   } mul_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [COV_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [COV_W-1:0] quo;
   } div_rsp_type;

   function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SUM_W-1:0] v);
      logic signed [COV_W-1:0] r;
      if (v > SUM_W'(COV_MAX)) begin
         r = COV_MAX;
      end else if (v < SUM_W'(COV_MIN)) begin
         r = COV_MIN;
      end else begin
         r = v[COV_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [EST_W-1:0] sat_lim(input logic signed [SUM_W-1:0] v,
                                                       input logic signed [EST_W-1:0] lim);
      logic signed [EST_W-1:0] r;
      if (v > SUM_W'(lim)) begin
         r = lim;
      end else if (v < -SUM_W'(lim)) begin
         r = -lim;
      end else begin
         r = v[EST_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/angle_kalman_filter.sv
// Two-state (angle, gyro bias) Kalman filter: one result per accepted sample.
// Each item runs ten 42-step shift-add multiplies through one shared serial multiplier
// and two 39-step gain divisions through one serial divider; the next item is taken
// once the current one has its result registered, and a result waiting on rsp_stall
// does not block the next input.
// Angles and rates are signed fixed point with FRAC_BITS fraction bits.
// Depends on akf_pkg, akf_mul, akf_div and angle_kalman_filter_defines.svh.
`timescale 1ns / 1ps
`include "angle_kalman_filter_defines.svh"

module angle_kalman_filter import akf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ACCEL_W-1:0]     req_accel_angle,
   input  logic signed [GYRO_W-1:0]      req_gyro_rate,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_OUT_W-1:0] rsp_filtered_angle,
   output logic signed [RATE_OUT_W-1:0]  rsp_angle_rate,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]              csr_data
);

   localparam longint INT32_TOP = 64'sd2147483647;
   localparam longint ANGLE_RAW = longint'(360) << FRAC_BITS;
   localparam longint BIAS_RAW  = longint'(2000) << FRAC_BITS;
   localparam logic signed [EST_W-1:0] ANGLE_LIM =
      EST_W'((ANGLE_RAW < INT32_TOP) ? ANGLE_RAW : INT32_TOP);
   localparam logic signed [EST_W-1:0] BIAS_LIM =
      EST_W'((BIAS_RAW < INT32_TOP) ? BIAS_RAW : INT32_TOP);
   localparam int RATE_SUM_W = EST_W + 2;
   localparam int E_W = DEN_W + 1;
   localparam logic signed [RATE_SUM_W-1:0] RATE_MAX = RATE_SUM_W'(268435455);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      OP_ANG_PRED, OP_P00_PRED, OP_CROSS_PRED, OP_P11_PRED,
      OP_K0, OP_K1,
      OP_P10_CORR, OP_P11_CORR, OP_P00_CORR, OP_P01_CORR,
      OP_BIAS_CORR, OP_ANG_CORR
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_NOISE, CSR_BIAS_NOISE, CSR_MEAS_NOISE, CSR_SAMPLE_PERIOD
   } csr_index_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [CFG_W-1:0] qa_ff, qg_ff, r_ff, dt_ff;
   logic signed [ACCEL_W-1:0] acc_ff;
   logic signed [GYRO_W-1:0]  gyr_ff;
   logic signed [EST_W-1:0]   ang_ff, bias_ff;
   logic signed [COV_W-1:0]   p00_ff, p01_ff, p10_ff, p11_ff, k0_ff, k1_ff;
   logic                      rsp_valid_ff;
   logic signed [ANGLE_OUT_W-1:0] rsp_angle_ff;
   logic signed [RATE_OUT_W-1:0]  rsp_rate_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic is_div_op, unit_done, e_pos, out_free;
   logic signed [E_W-1:0]    e_x;
   logic signed [OPND_W-1:0] opa, opb, dt_x, qa_x, qg_x, err_x;
   logic signed [SUM_W-1:0]  base, madd, sum, sum10;
   logic signed [RATE_SUM_W-1:0] rate_x;
   logic signed [RATE_OUT_W-1:0] rate_sat;

   akf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   akf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // operand and write-back selection
   always_comb begin
      is_div_op = (op_ff == OP_K0) || (op_ff == OP_K1);
      unit_done = is_div_op ? div_rsp.done : mul_rsp.done;
      e_x       = E_W'(p00_ff) + $signed(E_W'(r_ff));
      e_pos     = (e_x > 0);
      dt_x      = $signed(OPND_W'(dt_ff));
      qa_x      = $signed(OPND_W'(qa_ff));
      qg_x      = $signed(OPND_W'(qg_ff));
      err_x     = OPND_W'(acc_ff) - OPND_W'(ang_ff);
      opa       = '0;
      opb       = '0;
      base      = '0;
      case (op_ff)
         OP_ANG_PRED: begin
            opa  = OPND_W'(gyr_ff) - OPND_W'(bias_ff);
            opb  = dt_x;
            base = SUM_W'(ang_ff);
         end
         OP_P00_PRED: begin
            opa  = qa_x - OPND_W'(p01_ff) - OPND_W'(p10_ff);
            opb  = dt_x;
            base = SUM_W'(p00_ff);
         end
         OP_CROSS_PRED: begin
            opa  = -OPND_W'(p11_ff);
            opb  = dt_x;
            base = SUM_W'(p01_ff);
         end
         OP_P11_PRED: begin
            opa  = qg_x;
            opb  = dt_x;
            base = SUM_W'(p11_ff);
         end
         OP_P10_CORR: begin
            opa  = -OPND_W'(k1_ff);
            opb  = OPND_W'(p00_ff);
            base = SUM_W'(p10_ff);
         end
         OP_P11_CORR: begin
            opa  = -OPND_W'(k1_ff);
            opb  = OPND_W'(p01_ff);
            base = SUM_W'(p11_ff);
         end
         OP_P00_CORR: begin
            opa  = -OPND_W'(k0_ff);
            opb  = OPND_W'(p00_ff);
            base = SUM_W'(p00_ff);
         end
         OP_P01_CORR: begin
            opa  = -OPND_W'(k0_ff);
            opb  = OPND_W'(p01_ff);
            base = SUM_W'(p01_ff);
         end
         OP_BIAS_CORR: begin
            opa  = OPND_W'(k1_ff);
            opb  = err_x;
            base = SUM_W'(bias_ff);
         end
         OP_ANG_CORR: begin
            opa  = OPND_W'(k0_ff);
            opb  = err_x;
            base = SUM_W'(ang_ff);
         end
         default: begin
         end
      endcase
      madd  = $signed({{(SUM_W - RES_W){1'b0}}, mul_rsp.mag});
      if (mul_rsp.neg) begin
         madd = -madd;
      end
      sum   = base + madd;
      sum10 = SUM_W'(p10_ff) + madd;

      rate_x = RATE_SUM_W'(gyr_ff) - RATE_SUM_W'(bias_ff);
      if (rate_x > RATE_MAX) begin
         rate_sat = RATE_OUT_W'(RATE_MAX);
      end else if (rate_x < -RATE_MAX - 1) begin
         rate_sat = RATE_OUT_W'(-RATE_MAX - 1);
      end else begin
         rate_sat = rate_x[RATE_OUT_W-1:0];
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      mul_req.start      = (state_ff == ST_ISSUE) && !is_div_op;
      mul_req.shift_long = (op_ff == OP_ANG_PRED) || (op_ff == OP_P00_PRED) ||
                           (op_ff == OP_CROSS_PRED) || (op_ff == OP_P11_PRED);
      mul_req.a          = opa;
      mul_req.b          = opb;
      div_req.start      = (state_ff == ST_ISSUE) && is_div_op && e_pos;
      div_req.num        = (op_ff == OP_K0) ? p00_ff : p10_ff;
      div_req.den        = e_x[DEN_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
               op_in    = OP_ANG_PRED;
            end
         end
         ST_ISSUE: begin
            // innovation covariance not positive: gains drop to zero, skip the divide
            if (is_div_op && !e_pos) begin
               op_in = op_type'(op_ff + 1'b1);
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (unit_done) begin
               if (op_ff == OP_ANG_CORR) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ISSUE;
                  op_in    = op_type'(op_ff + 1'b1);
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ANG_PRED;
         rsp_valid_ff <= 1'b0;
         qa_ff        <= ANGLE_NOISE_RST;
         qg_ff        <= BIAS_NOISE_RST;
         r_ff         <= MEAS_NOISE_RST;
         dt_ff        <= SAMPLE_PERIOD_RST;
         ang_ff       <= '0;
         bias_ff      <= '0;
         p00_ff       <= COV_ONE;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= COV_ONE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ANGLE_NOISE:   qa_ff <= csr_data;
               CSR_BIAS_NOISE:    qg_ff <= csr_data;
               CSR_MEAS_NOISE:    r_ff  <= csr_data;
               CSR_SAMPLE_PERIOD: dt_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if ((state_ff == ST_WAIT) && unit_done) begin
            case (op_ff)
               OP_ANG_PRED, OP_ANG_CORR: ang_ff <= sat_lim(sum, ANGLE_LIM);
               OP_BIAS_CORR:             bias_ff <= sat_lim(sum, BIAS_LIM);
               OP_P00_PRED, OP_P00_CORR: p00_ff <= sat_cov(sum);
               OP_P01_CORR:              p01_ff <= sat_cov(sum);
               OP_P10_CORR:              p10_ff <= sat_cov(sum);
               OP_P11_PRED, OP_P11_CORR: p11_ff <= sat_cov(sum);
               OP_CROSS_PRED: begin
                  p01_ff <= sat_cov(sum);
                  p10_ff <= sat_cov(sum10);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         acc_ff <= req_accel_angle;
         gyr_ff <= req_gyro_rate;
      end
      if ((state_ff == ST_ISSUE) && is_div_op && !e_pos) begin
         k0_ff <= '0;
         k1_ff <= '0;
      end
      if ((state_ff == ST_WAIT) && div_rsp.done) begin
         if (op_ff == OP_K0) begin
            k0_ff <= div_rsp.quo;
         end else begin
            k1_ff <= div_rsp.quo;
         end
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_angle_ff <= ang_ff[ANGLE_OUT_W-1:0];
         rsp_rate_ff  <= rate_sat;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_angle_ff;
   assign rsp_angle_rate     = rsp_rate_ff;

   `AKF_ASSERT(ang_in_range_a, clock, reset, 1'b1, (ang_ff <= ANGLE_LIM) && (ang_ff >= -ANGLE_LIM), "angle estimate beyond limit")
   `AKF_ASSERT(bias_in_range_a, clock, reset, 1'b1, (bias_ff <= BIAS_LIM) && (bias_ff >= -BIAS_LIM), "bias estimate beyond limit")
   `AKF_ASSERT(mul_done_waits_a, clock, reset, mul_rsp.done, (state_ff == ST_WAIT) && !is_div_op, "multiplier result lost")
   `AKF_ASSERT(div_done_waits_a, clock, reset, div_rsp.done, (state_ff == ST_WAIT) && is_div_op, "divider result lost")
   `AKF_ASSERT_NEXT(out_loads_a, clock, reset, (state_ff == ST_OUT) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "result not posted")

endmodule

// File: hw/rtl/akf_mul.sv
// Bit-serial signed multiplier with rounded right shift by 28 or 32.
// Depends on akf_pkg; result is sign plus magnitude.
`timescale 1ns / 1ps

module akf_mul import akf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam int CNT_W = $clog2(MUL_STEPS);

   logic             prep_ff, busy_ff, fin_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [OPND_W-1:0] ma_ff, mb_ff;
   logic [PROD_W-1:0] acc_ff;
   logic             neg_ff, long_ff;
   logic [RES_W-1:0] mag_ff;

   logic [OPND_W-1:0] ma_abs, mb_abs, addend;
   logic [OPND_W:0]   step_sum;
   logic [PROD_W-1:0] acc_in;
   logic [RES_W-1:0]  mag_in;
   logic              last_step;

   always_comb begin
      ma_abs    = ma_ff[OPND_W-1] ? (~ma_ff + 1'b1) : ma_ff;
      mb_abs    = mb_ff[OPND_W-1] ? (~mb_ff + 1'b1) : mb_ff;
      addend    = mb_ff[0] ? ma_ff : '0;
      step_sum  = {1'b0, acc_ff[PROD_W-1:OPND_W]} + {1'b0, addend};
      acc_in    = {step_sum, acc_ff[OPND_W-1:1]};
      last_step = (cnt_ff == CNT_W'(MUL_STEPS - 1));
      if (long_ff) begin
         mag_in = RES_W'(acc_ff[PROD_W-1:SHIFT_LONG]) + RES_W'(acc_ff[SHIFT_LONG-1]);
      end else begin
         mag_in = RES_W'(acc_ff[PROD_W-1:SHIFT_SHORT]) + RES_W'(acc_ff[SHIFT_SHORT-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         prep_ff <= req.start;
         fin_ff  <= busy_ff && last_step;
         done_ff <= fin_ff;
         if (prep_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            busy_ff <= !last_step;
            cnt_ff  <= cnt_ff + 1'b1;
         end
      end
   end

   // operands arrive raw, turn into magnitudes in the following cycle
   always_ff @(posedge clock) begin
      if (req.start) begin
         ma_ff   <= req.a;
         mb_ff   <= req.b;
         neg_ff  <= req.a[OPND_W-1] ^ req.b[OPND_W-1];
         long_ff <= req.shift_long;
         acc_ff  <= '0;
      end else if (prep_ff) begin
         ma_ff <= ma_abs;
         mb_ff <= mb_abs;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         mb_ff  <= mb_ff >> 1;
      end
      if (fin_ff) begin
         mag_ff <= mag_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.neg  = neg_ff;
   assign rsp.mag  = mag_ff;

endmodule

// File: hw/rtl/akf_div.sv
// Restoring divider for the Kalman gain: |num| * 2^28 / den, saturated, with the sign of num.
// Depends on akf_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module akf_div import akf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, fin_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             sat_ff, neg_ff;
   logic [DEN_W-1:0] den_ff, rem_ff;
   logic [DIV_STEPS-1:0] nlo_ff, q_ff;
   logic signed [COV_W-1:0] quo_ff;

   logic [COV_W-1:0] num_abs;
   logic             sat_in, last_step, ge;
   logic [DEN_W:0]   trial, diff;
   logic [COV_W-1:0] q_ext;

   always_comb begin
      num_abs   = req.num[COV_W-1] ? (~req.num + 1'b1) : req.num;
      sat_in    = (DEN_W'(0) + (DEN_W + GAIN_INT)'(num_abs)) >= {req.den, GAIN_INT'(0)};
      last_step = (cnt_ff == CNT_W'(DIV_STEPS - 1));
      trial     = {rem_ff, nlo_ff[DIV_STEPS-1]};
      diff      = trial - {1'b0, den_ff};
      ge        = (trial >= {1'b0, den_ff});
      q_ext     = {1'b0, q_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff  <= (req.start && sat_in) || (busy_ff && last_step);
         done_ff <= fin_ff;
         if (req.start) begin
            busy_ff <= !sat_in;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            busy_ff <= !last_step;
            cnt_ff  <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         sat_ff <= sat_in;
         neg_ff <= req.num[COV_W-1];
         den_ff <= req.den;
         rem_ff <= DEN_W'(num_abs >> GAIN_INT);
         nlo_ff <= {num_abs[GAIN_INT-1:0], GAIN_FRAC'(0)};
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         nlo_ff <= nlo_ff << 1;
         q_ff   <= {q_ff[DIV_STEPS-2:0], ge};
      end
      if (fin_ff) begin
         if (sat_ff) begin
            quo_ff <= neg_ff ? COV_MIN : COV_MAX;
         end else begin
            quo_ff <= neg_ff ? -q_ext : q_ext;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule
